// ===== hdl/ssca_pkg.sv =====
`default_nettype none
package ssca_pkg;

   localparam int PAGE_BYTES     = 4096;
   localparam int PAGES_PER_SLAB = 4;
   localparam int HEADER_BYTES   = 16;
   localparam int MAX_SLABS      = 16;
   localparam int SIZE_CLASSES   = 8;

   localparam int CLS_W   = 3;
   localparam int SLAB_W  = 4;
   localparam int OPEN_W  = 5;
   localparam int SLOT_W  = 9;
   localparam int CNT_W   = 10;
   localparam int WORD_W  = 3;
   localparam int BIT_W   = 6;
   localparam int ID_W    = CLS_W + SLAB_W;
   localparam int OADDR_W = ID_W + WORD_W;
   localparam int MAX_SLOTS = 512;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_MEMORY = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_BUMP,
      S_SET,
      S_SCAN,
      S_FREE,
      S_RESP
   } state_type;

   localparam logic CMD_FREE = 1'b1;

   localparam int SLAB_BYTES = PAGE_BYTES * PAGES_PER_SLAB;
   localparam int N0 = SLAB_BYTES / ((16 << 0) + HEADER_BYTES);
   localparam int N1 = SLAB_BYTES / ((16 << 1) + HEADER_BYTES);
   localparam int N2 = SLAB_BYTES / ((16 << 2) + HEADER_BYTES);
   localparam int N3 = SLAB_BYTES / ((16 << 3) + HEADER_BYTES);
   localparam int N4 = SLAB_BYTES / ((16 << 4) + HEADER_BYTES);
   localparam int N5 = SLAB_BYTES / ((16 << 5) + HEADER_BYTES);
   localparam int N6 = SLAB_BYTES / ((16 << 6) + HEADER_BYTES);
   localparam int N7 = SLAB_BYTES / ((16 << 7) + HEADER_BYTES);

   function automatic logic [CNT_W-1:0] cap(input int n);
      int r;
      begin
         r = (n > MAX_SLOTS) ? MAX_SLOTS : n;
         return CNT_W'(r);
      end
   endfunction

   function automatic logic [CNT_W-1:0] slots_of(input logic [CLS_W-1:0] c);
      logic [CNT_W-1:0] r;
      begin
         case (c)
            3'd0: r = cap(N0);
            3'd1: r = cap(N1);
            3'd2: r = cap(N2);
            3'd3: r = cap(N3);
            3'd4: r = cap(N4);
            3'd5: r = cap(N5);
            3'd6: r = cap(N6);
            3'd7: r = cap(N7);
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/slab_size_class_allocator.sv =====
// Slab allocator, eight power-of-two size classes (16..2048 bytes).
// req channel: one transaction per command. tuser = command (0 alloc,
// 1 free); tdata = request_size, free_class, free_slab, free_slot.
// rsp channel: exactly one transaction per request carrying status and the
// granted class/slab/slot (zero unless an allocate succeeds).
// Occupancy lives in a 1024 x 64 memory (8 words per slab), bump indexes
// in a 128 x 10 memory; both are read through an output register.
// An allocation walks the open slabs of its class (S_WALK), skipping slabs
// marked full and opening a new slab past the last; it reads the bump index
// (S_BUMP) and takes the bump slot (S_SET), or else scans the occupancy words
// of a slab whose bump index is spent (S_SCAN), marking it full and walking on
// if no slot is clear. A free reads and clears its set bit (S_FREE); a rejected
// request goes straight to S_RESP. One request is worked on at a time; the
// next is accepted the cycle after the result enters the output register.
// Reset: all slots free, one open slab per class. Occupancy words past a
// slab's bump index read as zero, so no clearing pass is needed.
// A stalled rsp_tready holds the result; the block then waits with the
// following result until the output register frees.
`default_nettype none
module slab_size_class_allocator
   import ssca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // request_size, free_class, free_slab, free_slot
   input  wire logic        req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // status, granted_class, granted_slab, granted_slot
);

   logic [63:0]        occ_mem [1 << OADDR_W];
   logic [CNT_W-1:0]   bump_mem [1 << ID_W];

   state_type          state_ff, state_in;
   logic [CLS_W-1:0]   cls_ff, cls_in;
   logic [OPEN_W-1:0]  slab_ff, slab_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [OPEN_W-1:0]  open_ff [SIZE_CLASSES];
   logic [OPEN_W-1:0]  open_in [SIZE_CLASSES];
   logic [(1 << ID_W)-1:0] full_ff, full_in;
   logic [(1 << ID_W)-1:0] bvld_ff;

   status_type         res_status_ff, res_status_in;
   logic [CLS_W-1:0]   res_cls_ff, res_cls_in;
   logic [SLAB_W-1:0]  res_slab_ff, res_slab_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;

   logic               rsp_tvalid_ff;
   logic [23:0]        rsp_tdata_ff;

   logic               occ_re, occ_we;
   logic [OADDR_W-1:0] occ_raddr, occ_waddr;
   logic [63:0]        occ_wdata, occ_rd_ff;
   logic               bump_re, bump_we;
   logic [ID_W-1:0]    bump_raddr, bump_waddr;
   logic [CNT_W-1:0]   bump_wdata, bump_rd_ff;
   logic               bump_rdv_ff;

   logic               accept, rsp_load;
   logic [31:0]        f_size;
   logic [CLS_W-1:0]   f_cls;
   logic [SLAB_W-1:0]  f_slab;
   logic [SLOT_W-1:0]  f_slot;
   logic               alloc_too;
   logic [CLS_W-1:0]   alloc_cls;
   logic               free_bad;
   logic [CNT_W-1:0]   n;
   logic [CNT_W-1:0]   n_m1;
   logic [ID_W-1:0]    id;
   logic [OPEN_W-1:0]  open_c;
   logic               walk_in, walk_new;
   logic [CNT_W-1:0]   bump_cur;
   logic               bump_has;
   logic [63:0]        scan_mask, scan_word;
   logic               scan_found, scan_last;
   logic [BIT_W-1:0]   scan_idx;
   logic [63:0]        free_word;
   logic               free_hit;

   assign f_size = req_tdata[31:0];
   assign f_cls  = req_tdata[34:32];
   assign f_slab = req_tdata[38:35];
   assign f_slot = req_tdata[47:39];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // size class: bit length of size-1, less four
   always_comb begin
      logic [10:0] v;
      logic [3:0]  bl;
      v  = 11'(f_size - 32'd1);
      bl = '0;
      for (int i = 0; i < 11; i++) begin
         if (v[i]) bl = 4'(i + 1);
      end
      alloc_cls = (bl >= 4'd4) ? 3'(bl - 4'd4) : '0;
      alloc_too = (f_size == 32'd0) || (f_size > 32'd2048) ||
                  (32'(alloc_cls) >= 32'(SIZE_CLASSES));
   end

   assign free_bad = (32'(f_cls) >= 32'(SIZE_CLASSES)) ||
                     ({1'b0, f_slab} >= open_ff[f_cls]) ||
                     ({1'b0, f_slot} >= slots_of(f_cls));

   assign n        = slots_of(cls_ff);
   assign n_m1     = n - CNT_W'(1);
   assign id       = {cls_ff, slab_ff[SLAB_W-1:0]};
   assign open_c   = open_ff[cls_ff];
   assign walk_in  = slab_ff < open_c;
   assign walk_new = OPEN_W'(MAX_SLABS) > open_c;
   assign bump_cur = bump_rdv_ff ? bump_rd_ff : '0;
   assign bump_has = bump_cur < n;

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         scan_mask[i] = {1'b0, word_ff, 6'(i)} >= n;
      end
      scan_word  = occ_rd_ff | scan_mask;
      scan_found = 1'b0;
      scan_idx   = '0;
      for (int i = 63; i >= 0; i--) begin
         if (!scan_word[i]) begin
            scan_found = 1'b1;
            scan_idx   = 6'(i);
         end
      end
   end
   assign scan_last = (word_ff == n_m1[8:6]);

   assign free_word = ({1'b0, slot_ff[8:6], 6'd0} < bump_cur) ? occ_rd_ff : '0;
   assign free_hit  = free_word[slot_ff[5:0]];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_FREE) state_in = free_bad ? S_RESP : S_FREE;
               else state_in = alloc_too ? S_RESP : S_WALK;
            end
         end
         S_WALK: begin
            if (walk_in) begin
               if (!full_ff[id]) state_in = S_BUMP;
            end else if (walk_new) begin
               state_in = S_BUMP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_BUMP: state_in = bump_has ? S_SET : S_SCAN;
         S_SET:  state_in = S_RESP;
         S_SCAN: begin
            if (scan_found) state_in = S_RESP;
            else if (scan_last) state_in = S_WALK;
         end
         S_FREE: state_in = S_RESP;
         S_RESP: if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cls_in        = cls_ff;
      slab_in       = slab_ff;
      word_in       = word_ff;
      slot_in       = slot_ff;
      open_in       = open_ff;
      full_in       = full_ff;
      res_status_in = res_status_ff;
      res_cls_in    = res_cls_ff;
      res_slab_in   = res_slab_ff;
      res_slot_in   = res_slot_ff;
      occ_re        = 1'b0;
      occ_raddr     = {id, word_ff};
      occ_we        = 1'b0;
      occ_waddr     = {id, word_ff};
      occ_wdata     = occ_rd_ff;
      bump_re       = 1'b0;
      bump_raddr    = id;
      bump_we       = 1'b0;
      bump_waddr    = id;
      bump_wdata    = bump_cur + CNT_W'(1);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = ST_OK;
               res_cls_in    = '0;
               res_slab_in   = '0;
               res_slot_in   = '0;
               slab_in       = '0;
               if (req_tuser == CMD_FREE) begin
                  cls_in  = f_cls;
                  slab_in = {1'b0, f_slab};
                  slot_in = f_slot;
                  if (free_bad) begin
                     res_status_in = ST_BAD_FREE;
                  end else begin
                     bump_re    = 1'b1;
                     bump_raddr = {f_cls, f_slab};
                     occ_re     = 1'b1;
                     occ_raddr  = {f_cls, f_slab, f_slot[8:6]};
                  end
               end else begin
                  cls_in = alloc_cls;
                  if (alloc_too) res_status_in = ST_TOO_LARGE;
               end
            end
         end
         S_WALK: begin
            if (walk_in) begin
               if (full_ff[id]) slab_in = slab_ff + OPEN_W'(1);
               else bump_re = 1'b1;
            end else if (walk_new) begin
               open_in[cls_ff] = open_c + OPEN_W'(1);
               bump_re = 1'b1;
            end else begin
               res_status_in = ST_NO_MEMORY;
            end
         end
         S_BUMP: begin
            occ_re = 1'b1;
            if (bump_has) begin
               slot_in   = bump_cur[SLOT_W-1:0];
               bump_we   = 1'b1;
               occ_raddr = {id, bump_cur[8:6]};
            end else begin
               word_in   = '0;
               occ_raddr = {id, {WORD_W{1'b0}}};
            end
         end
         S_SET: begin
            occ_we      = 1'b1;
            occ_waddr   = {id, slot_ff[8:6]};
            occ_wdata   = ((slot_ff[5:0] == '0) ? 64'd0 : occ_rd_ff) |
                          (64'd1 << slot_ff[5:0]);
            res_cls_in  = cls_ff;
            res_slab_in = slab_ff[SLAB_W-1:0];
            res_slot_in = slot_ff;
         end
         S_SCAN: begin
            if (scan_found) begin
               occ_we      = 1'b1;
               occ_wdata   = occ_rd_ff | (64'd1 << scan_idx);
               res_cls_in  = cls_ff;
               res_slab_in = slab_ff[SLAB_W-1:0];
               res_slot_in = {word_ff, scan_idx};
            end else if (scan_last) begin
               full_in[id] = 1'b1;
               slab_in     = slab_ff + OPEN_W'(1);
            end else begin
               word_in   = word_ff + WORD_W'(1);
               occ_re    = 1'b1;
               occ_raddr = {id, word_ff + WORD_W'(1)};
            end
         end
         S_FREE: begin
            if (free_hit) begin
               occ_we      = 1'b1;
               occ_waddr   = {id, slot_ff[8:6]};
               occ_wdata   = free_word & ~(64'd1 << slot_ff[5:0]);
               full_in[id] = 1'b0;
            end else begin
               res_status_in = ST_BAD_FREE;
            end
         end
         S_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (occ_re) occ_rd_ff <= occ_mem[occ_raddr];
      if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
      if (bump_re) begin
         bump_rd_ff  <= bump_mem[bump_raddr];
         bump_rdv_ff <= bvld_ff[bump_raddr];
      end
      if (bump_we) bump_mem[bump_waddr] <= bump_wdata;
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      slab_ff       <= slab_in;
      word_ff       <= word_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_cls_ff    <= res_cls_in;
      res_slab_ff   <= res_slab_in;
      res_slot_ff   <= res_slot_in;
      if (rsp_load) begin
         rsp_tdata_ff <= {6'd0, res_slot_ff, res_slab_ff, res_cls_ff, res_status_ff};
      end
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         full_ff       <= '0;
         bvld_ff       <= '0;
         for (int c = 0; c < SIZE_CLASSES; c++) open_ff[c] <= OPEN_W'(1);
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
         open_ff  <= open_in;
         if (bump_we) bvld_ff[bump_waddr] <= 1'b1;
         if (rsp_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

`ifndef SYNTH
   a_open_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |->
      ((open_ff[cls_ff] != '0) && (open_ff[cls_ff] <= OPEN_W'(MAX_SLABS))))
      else $error("open slab count out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid_ff)
      else $error("result lost on output register load");

   a_occ_port: assert property (@(posedge clock) disable iff (reset)
      occ_we |-> ((state_ff == S_SET) || (state_ff == S_SCAN) || (state_ff == S_FREE)))
      else $error("occupancy written outside an update state");
`endif

endmodule
`default_nettype wire
